FILE: rtl/tcm_pkg.sv
package tcm_pkg;

   localparam int MaxVars    = 6;
   localparam int Minterms   = 64;
   localparam int PrimeSlots = 64;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIDE_INIT,
      ST_FIND,
      ST_ESS_COUNT,
      ST_ESS_MARK,
      ST_GREEDY_CHECK,
      ST_GREEDY_SCAN,
      ST_GREEDY_APPLY,
      ST_EMIT_PRIMES,
      ST_EMIT_EXTRAS,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_HOLD
   } state_type;

   // one cube: fixed bits (zero where dashed) and dash mask
   typedef struct packed {
      logic [5:0] value;
      logic [5:0] dashes;
   } cube_type;

   // candidate test results from the evaluator
   typedef struct packed {
      logic shape_ok;
      logic in_table;
      logic no_expand;
   } cand_result_type;

   // minterms covered by a cube
   function automatic logic [Minterms-1:0] cube_mask(cube_type c);
      logic [Minterms-1:0] r;
      for (int j = 0; j < Minterms; j++) begin
         r[j] = ((6'(j) & ~c.dashes) == c.value);
      end
      return r;
   endfunction

   function automatic logic [6:0] popcount64(logic [Minterms-1:0] v);
      logic [6:0] s;
      s = '0;
      for (int j = 0; j < Minterms; j++) begin
         s = s + 7'(v[j]);
      end
      return s;
   endfunction

   function automatic logic [2:0] popcount6(logic [5:0] v);
      logic [2:0] s;
      s = '0;
      for (int j = 0; j < 6; j++) begin
         s = s + 3'(v[j]);
      end
      return s;
   endfunction

   // index of lowest set bit, zero when empty
   function automatic logic [5:0] lowest64(logic [Minterms-1:0] v);
      logic [5:0] r;
      r = '0;
      for (int j = Minterms - 1; j >= 0; j--) begin
         if (v[j]) begin
            r = 6'(j);
         end
      end
      return r;
   endfunction

   // valid combinations for n inputs
   function automatic logic [Minterms-1:0] full_mask(logic [2:0] n);
      logic [Minterms-1:0] r;
      for (int j = 0; j < Minterms; j++) begin
         r[j] = (7'(j) < (7'd1 << n));
      end
      return r;
   endfunction

endpackage

FILE: rtl/truth_table_cover_minimizer.sv
// Channel | Ports                                          | Direction
// req     | req_valid req_ready req_truth_table req_var_count | in
// rsp     | rsp_valid rsp_ready rsp_cube_value rsp_cube_dashes
//         | rsp_off_side rsp_last_cube                      | out
// Per table and side: a candidate scan over the shared evaluator for each dash count,
// value and dash mask, then sweeps over the stored primes (two essential passes, one
// per greedy pick, one emit) and one over the extra cubes; results then leave one by
// one, each held until rsp_ready.
// Reset is synchronous and clears the sequencer; req_ready is high only in idle.
module truth_table_cover_minimizer import tcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_truth_table,
   input  logic [2:0]  req_var_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_cube_value,
   output logic [5:0]  rsp_cube_dashes,
   output logic        rsp_off_side,
   output logic        rsp_last_cube
);

   state_type state_ff, state_in;

   logic [Minterms-1:0] tbl_ff, tbl_in, cur_tbl_ff, cur_tbl_in;
   logic [Minterms-1:0] unc_ff, unc_in, seen1_ff, seen1_in, seen2_ff, seen2_in;
   logic [PrimeSlots-1:0] chosen_ff, chosen_in;
   logic [2:0] n_ff, n_in, d_ff, d_in;
   logic [5:0] x_ff, x_in, m_ff, m_in, low_ff, low_in, best_idx_ff, best_idx_in;
   logic [6:0] pcount_ff, pcount_in, idx_ff, idx_in, nf_ff, nf_in, k_ff, k_in;
   logic [6:0] oidx_ff, oidx_in, bestp_ff, bestp_in;
   logic       phase_ff, phase_in, side_ff, side_in, found_ff, found_in;
   cube_type   best_cube_ff, best_cube_in;
   logic [5:0] rsp_value_ff, rsp_value_in, rsp_dashes_ff, rsp_dashes_in;
   logic       rsp_side_ff, rsp_side_in, rsp_last_ff, rsp_last_in;

   // memories
   cube_type   prime_mem [PrimeSlots];
   cube_type   prime_rd_ff;
   logic [5:0] extra_mem [Minterms];
   logic [5:0] extra_rd_ff;
   logic [12:0] result_mem [Minterms];
   logic [12:0] result_rd_ff;

   logic        prime_we, extra_we, result_we;
   logic [12:0] result_wdata;

   logic [2:0]          var_n;
   logic [5:0]          lim_max;
   logic                last_cand, sweep_end, extra_end;
   logic [Minterms-1:0] cm_rd;
   logic [6:0]          pop_rd;
   cube_type            cand;
   cand_result_type     cand_res;
   logic                cand_ok;

   // candidate evaluator
   assign cand.value  = x_ff;
   assign cand.dashes = m_ff;

   tcm_cand_eval u_eval (
      .cand       (cand),
      .dash_count (d_ff),
      .var_n      (n_ff),
      .tbl        (cur_tbl_ff),
      .result     (cand_res)
   );

   // shared status terms
   always_comb begin
      var_n     = (req_var_count > 3'(MaxVars)) ? 3'(MaxVars) : req_var_count;
      lim_max   = 6'((7'd1 << n_ff) - 7'd1);
      last_cand = (d_ff == n_ff) && (x_ff == lim_max) && (m_ff == lim_max);
      cand_ok   = cand_res.shape_ok && cand_res.in_table && cand_res.no_expand;
      sweep_end = !phase_ff && (idx_ff == pcount_ff);
      extra_end = !phase_ff && (idx_ff == nf_ff);
      cm_rd     = cube_mask(prime_rd_ff);
      pop_rd    = popcount64(cm_rd & unc_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:         if (req_valid) state_in = ST_SIDE_INIT;
         ST_SIDE_INIT:    state_in = ST_FIND;
         ST_FIND:         if (last_cand) state_in = ST_ESS_COUNT;
         ST_ESS_COUNT:    if (sweep_end) state_in = ST_ESS_MARK;
         ST_ESS_MARK:     if (sweep_end) state_in = ST_GREEDY_CHECK;
         ST_GREEDY_CHECK: state_in = (unc_ff == '0) ? ST_EMIT_PRIMES : ST_GREEDY_SCAN;
         ST_GREEDY_SCAN:  if (sweep_end) state_in = ST_GREEDY_APPLY;
         ST_GREEDY_APPLY: state_in = ST_GREEDY_CHECK;
         ST_EMIT_PRIMES:  if (sweep_end) state_in = ST_EMIT_EXTRAS;
         ST_EMIT_EXTRAS: begin
            if (extra_end) state_in = side_ff ? ST_OUT_READ : ST_SIDE_INIT;
         end
         ST_OUT_READ:     state_in = ST_OUT_LOAD;
         ST_OUT_LOAD:     state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp_ready) state_in = rsp_last_ff ? ST_IDLE : ST_OUT_READ;
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // outputs and write enables
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = (state_ff == ST_OUT_HOLD);
      prime_we     = (state_ff == ST_FIND) && cand_ok && !pcount_ff[6];
      extra_we     = (state_ff == ST_GREEDY_APPLY) && !found_ff && !nf_ff[6];
      result_we    = 1'b0;
      result_wdata = {side_ff, prime_rd_ff};
      case (state_ff)
         ST_EMIT_PRIMES: result_we = phase_ff && chosen_ff[idx_ff[5:0]] && !k_ff[6];
         ST_EMIT_EXTRAS: begin
            result_we    = phase_ff && !k_ff[6];
            result_wdata = {side_ff, extra_rd_ff, 6'd0};
         end
         default:        result_we = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      tbl_in       = tbl_ff;
      cur_tbl_in   = cur_tbl_ff;
      unc_in       = unc_ff;
      seen1_in     = seen1_ff;
      seen2_in     = seen2_ff;
      chosen_in    = chosen_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      m_in         = m_ff;
      low_in       = low_ff;
      best_idx_in  = best_idx_ff;
      best_cube_in = best_cube_ff;
      bestp_in     = bestp_ff;
      found_in     = found_ff;
      pcount_in    = pcount_ff;
      nf_in        = nf_ff;
      k_in         = k_ff;
      side_in      = side_ff;
      oidx_in      = oidx_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_dashes_in = rsp_dashes_ff;
      rsp_side_in   = rsp_side_ff;
      rsp_last_in   = rsp_last_ff;

      // sweep index: restart on entry, else read then use
      if (state_in != state_ff) begin
         idx_in   = '0;
         phase_in = 1'b0;
      end else if (!phase_ff) begin
         phase_in = 1'b1;
      end else begin
         phase_in = 1'b0;
         idx_in   = idx_ff + 7'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            n_in    = var_n;
            tbl_in  = req_truth_table & full_mask(var_n);
            side_in = 1'b0;
            k_in    = '0;
         end
         ST_SIDE_INIT: begin
            cur_tbl_in = side_ff ? (~tbl_ff & full_mask(n_ff)) : tbl_ff;
            unc_in     = cur_tbl_in;
            chosen_in  = '0;
            seen1_in   = '0;
            seen2_in   = '0;
            pcount_in  = '0;
            nf_in      = '0;
            d_in       = '0;
            x_in       = '0;
            m_in       = '0;
         end
         ST_FIND: begin
            if (prime_we) pcount_in = pcount_ff + 7'd1;
            if (m_ff == lim_max) begin
               m_in = '0;
               if (x_ff == lim_max) begin
                  x_in = '0;
                  d_in = d_ff + 3'd1;
               end else begin
                  x_in = x_ff + 6'd1;
               end
            end else begin
               m_in = m_ff + 6'd1;
            end
         end
         ST_ESS_COUNT: begin
            if (phase_ff) begin
               seen2_in = seen2_ff | (seen1_ff & cm_rd);
               seen1_in = seen1_ff | cm_rd;
            end
         end
         ST_ESS_MARK: begin
            if (phase_ff && ((cm_rd & ~seen2_ff) != '0)) begin
               chosen_in[idx_ff[5:0]] = 1'b1;
               unc_in = unc_ff & ~cm_rd;
            end
         end
         ST_GREEDY_CHECK: begin
            low_in   = lowest64(unc_ff);
            found_in = 1'b0;
            bestp_in = '0;
         end
         ST_GREEDY_SCAN: begin
            if (phase_ff && cm_rd[low_ff] && (pop_rd > bestp_ff)) begin
               best_idx_in  = idx_ff[5:0];
               best_cube_in = prime_rd_ff;
               bestp_in     = pop_rd;
               found_in     = 1'b1;
            end
         end
         ST_GREEDY_APPLY: begin
            if (found_ff) begin
               chosen_in[best_idx_ff] = 1'b1;
               unc_in = unc_ff & ~cube_mask(best_cube_ff);
            end else begin
               nf_in          = nf_ff + 7'd1;
               unc_in[low_ff] = 1'b0;
            end
         end
         ST_EMIT_PRIMES: begin
            if (result_we) k_in = k_ff + 7'd1;
         end
         ST_EMIT_EXTRAS: begin
            if (result_we) k_in = k_ff + 7'd1;
            if (extra_end) begin
               side_in = 1'b1;
               oidx_in = '0;
            end
         end
         ST_OUT_LOAD: begin
            {rsp_side_in, rsp_value_in, rsp_dashes_in} = result_rd_ff;
            rsp_last_in = ((oidx_ff + 7'd1) == k_ff);
         end
         ST_OUT_HOLD: begin
            if (rsp_ready) oidx_in = oidx_ff + 7'd1;
         end
         default: begin
            oidx_in = oidx_ff;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         idx_ff   <= '0;
         unc_ff   <= '0;
         cur_tbl_ff <= '0;
         chosen_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         unc_ff   <= unc_in;
         cur_tbl_ff <= cur_tbl_in;
         chosen_ff <= chosen_in;
      end
      tbl_ff       <= tbl_in;
      seen1_ff     <= seen1_in;
      seen2_ff     <= seen2_in;
      n_ff         <= n_in;
      d_ff         <= d_in;
      x_ff         <= x_in;
      m_ff         <= m_in;
      low_ff       <= low_in;
      best_idx_ff  <= best_idx_in;
      best_cube_ff <= best_cube_in;
      bestp_ff     <= bestp_in;
      found_ff     <= found_in;
      pcount_ff    <= pcount_in;
      nf_ff        <= nf_in;
      k_ff         <= k_in;
      side_ff      <= side_in;
      oidx_ff      <= oidx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_dashes_ff <= rsp_dashes_in;
      rsp_side_ff   <= rsp_side_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // prime store
   always_ff @(posedge clock) begin
      if (prime_we) prime_mem[pcount_ff[5:0]] <= cand;
      prime_rd_ff <= prime_mem[idx_ff[5:0]];
   end

   // single-minterm cubes for minterms outside every stored prime
   always_ff @(posedge clock) begin
      if (extra_we) extra_mem[nf_ff[5:0]] <= low_ff;
      extra_rd_ff <= extra_mem[idx_ff[5:0]];
   end

   // result queue for both sides
   always_ff @(posedge clock) begin
      if (result_we) result_mem[k_ff[5:0]] <= result_wdata;
      result_rd_ff <= result_mem[oidx_ff[5:0]];
   end

   assign rsp_cube_value  = rsp_value_ff;
   assign rsp_cube_dashes = rsp_dashes_ff;
   assign rsp_off_side    = rsp_side_ff;
   assign rsp_last_cube   = rsp_last_ff;

`ifndef SYNTHESIS
   a_unc_in_side: assert property (@(posedge clock) disable iff (reset)
      (unc_ff & ~cur_tbl_ff) == '0)
      else $error("uncovered minterm outside current side");

   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (k_ff != 7'd0) && (oidx_ff < k_ff))
      else $error("transaction shown beyond result count");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_cube) |=> req_ready)
      else $error("not idle after final cube");

   a_apply_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GREEDY_APPLY) |=> ($countones(unc_ff) < $countones($past(unc_ff))))
      else $error("greedy step made no progress");
`endif

endmodule

FILE: rtl/tcm_cand_eval.sv
module tcm_cand_eval import tcm_pkg::*; (
   input  cube_type              cand,
   input  logic [2:0]            dash_count,
   input  logic [2:0]            var_n,
   input  logic [Minterms-1:0]   tbl,
   output cand_result_type       result
);

   logic [Minterms-1:0] cm;
   logic [Minterms-1:0] partner [6];
   logic [5:0]          can_grow;

   // cube cover and shape checks, then the neighbour cube across each
   // fixed input; prime if none fits
   always_comb begin
      cm              = cube_mask(cand);
      result.shape_ok = (popcount6(cand.dashes) == dash_count) &&
                        ((cand.value & cand.dashes) == 6'd0);
      result.in_table = ((cm & ~tbl) == '0);
      for (int b = 0; b < 6; b++) begin
         for (int j = 0; j < Minterms; j++) begin
            partner[b][j] = cm[j ^ (1 << b)];
         end
         can_grow[b] = (3'(b) < var_n) && !cand.dashes[b] &&
                       ((partner[b] & ~tbl) == '0);
      end
      result.no_expand = ~|can_grow;
   end

endmodule
